@@ hdl/led_driver_frame_serializer_top_assert.svh @@
// Assertion macros for the LED driver frame serializer.
`ifndef LED_DRIVER_FRAME_SERIALIZER_TOP_ASSERT_SVH
`define LED_DRIVER_FRAME_SERIALIZER_TOP_ASSERT_SVH

// Same-cycle implication, checked on clk, off during reset.
`define LFS_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, checked on clk, off during reset.
`define LFS_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

@@ hdl/lfs_pkg.sv @@
// Shared types and constants of the LED driver frame serializer.
package lfs_pkg;

	localparam int FRAME_BYTES = 32;
	localparam int POS_W = (FRAME_BYTES > 1) ? $clog2(FRAME_BYTES) : 1;
	localparam logic [POS_W-1:0] POS_LAST = POS_W'(FRAME_BYTES - 1);

	localparam int QUEUE_DEPTH = 2;
	localparam int QPTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int QCNT_W = $clog2(QUEUE_DEPTH + 1);

	localparam int BYTE_W = 8;
	localparam int CFG_IDX_W = 2;

	// Symbol counter within a segment: 0 is the strobe, 1..8 the data bits.
	localparam int CNT_W = 4;
	localparam logic [CNT_W-1:0] CNT_STROBE = CNT_W'(0);
	localparam logic [CNT_W-1:0] CNT_FIRST_BIT = CNT_W'(1);
	localparam logic [CNT_W-1:0] CNT_LAST_BIT = CNT_W'(BYTE_W);

	localparam logic SYM_STROBE = 1'b0;
	localparam logic SYM_DATA = 1'b1;

	localparam logic [BYTE_W-1:0] PAD_BYTE = 8'h00;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_MODE  = 2'd0,
		CFG_SETUP = 2'd1,
		CFG_ADDR  = 2'd2,
		CFG_CTRL  = 2'd3
	} cfg_reg_t;

	localparam logic [BYTE_W-1:0] RST_MODE  = 8'h08;
	localparam logic [BYTE_W-1:0] RST_SETUP = 8'h40;
	localparam logic [BYTE_W-1:0] RST_ADDR  = 8'hC0;
	localparam logic [BYTE_W-1:0] RST_CTRL  = 8'h8F;

	typedef enum logic [2:0] {
		SEG_MODE,
		SEG_SETUP,
		SEG_ADDR,
		SEG_DATA,
		SEG_PAD0,
		SEG_PAD1,
		SEG_CTRL
	} seg_t;

	// One classified byte: what the back end has to send for it.
	typedef struct packed {
		logic [BYTE_W-1:0] data;
		logic              header;
		logic              pad;
		logic              trailer;
	} job_t;

	typedef struct packed {
		logic [BYTE_W-1:0] mode;
		logic [BYTE_W-1:0] setup;
		logic [BYTE_W-1:0] addr;
		logic [BYTE_W-1:0] ctrl;
	} cmd_set_t;

	typedef struct packed {
		logic full;
		logic empty;
	} q_stat_t;

endpackage

@@ hdl/lfs_front.sv @@
// Front end: accept display bytes and tag each with its frame position work.
module lfs_front
	import lfs_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_stall,
	input  logic [BYTE_W-1:0] display_byte,
	input  q_stat_t           q_stat,
	output logic              push,
	output job_t              job
);

	logic [POS_W-1:0] pos_q;

	assign in_stall = q_stat.full;
	assign push = in_valid && !q_stat.full;

	assign job.data = display_byte;
	assign job.header = (pos_q == '0);
	assign job.pad = pos_q[0];
	assign job.trailer = (pos_q == POS_LAST);

	// Advance the frame position per accepted byte, wrap after the last.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q <= '0;
		end else if (push) begin
			if (pos_q == POS_LAST) begin
				pos_q <= '0;
			end else begin
				pos_q <= pos_q + POS_W'(1);
			end
		end
	end

endmodule

@@ hdl/lfs_queue.sv @@
// Short job queue between the front and back ends.
module lfs_queue
	import lfs_pkg::*;
(
	input  logic    clk,
	input  logic    arst_n,
	input  logic    push,
	input  job_t    push_job,
	input  logic    pop,
	output job_t    head,
	output q_stat_t q_stat
);

	job_t              slot_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QCNT_W-1:0] count_q;

	assign head = slot_q[rd_ptr_q];
	assign q_stat.full = (count_q == QCNT_W'(QUEUE_DEPTH));
	assign q_stat.empty = (count_q == '0);

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= push_job;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + QPTR_W'(1);
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + QPTR_W'(1);
			end
			if (push && !pop) begin
				count_q <= count_q + QCNT_W'(1);
			end else if (pop && !push) begin
				count_q <= count_q - QCNT_W'(1);
			end
		end
	end

endmodule

@@ hdl/lfs_back.sv @@
// Back end: sequence the serial symbols of the head job into the output register.
module lfs_back
	import lfs_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  cmd_set_t cmds,
	input  job_t     head,
	input  q_stat_t  q_stat,
	output logic     pop,
	output logic     out_valid,
	input  logic     out_stall,
	output logic     symbol_kind,
	output logic     bit_value,
	output logic     last_symbol
);

	logic              busy_q;
	seg_t              seg_q;
	logic [CNT_W-1:0]  cnt_q;
	logic              out_valid_q;
	logic              kind_q;
	logic              bit_q;
	logic              last_q;

	seg_t              eff_seg;
	logic [CNT_W-1:0]  eff_cnt;
	seg_t              nxt_seg;
	logic [CNT_W-1:0]  nxt_start;
	logic              seg_done;
	logic              seg_end;
	logic              is_last;
	logic [BYTE_W-1:0] cur_byte;
	logic [2:0]        bit_idx;
	logic              out_ready;
	logic              emit;

	assign out_ready = !out_valid_q || !out_stall;
	assign emit = !q_stat.empty && out_ready;

	always_comb begin
		eff_seg = busy_q ? seg_q : (head.header ? SEG_MODE : SEG_DATA);
		eff_cnt = busy_q ? cnt_q : (head.header ? CNT_STROBE : CNT_FIRST_BIT);
		nxt_seg = SEG_CTRL;
		seg_done = 1'b0;
		cur_byte = PAD_BYTE;
		unique case (eff_seg)
			SEG_MODE: begin
				nxt_seg = SEG_SETUP;
				cur_byte = cmds.mode;
			end
			SEG_SETUP: begin
				nxt_seg = SEG_ADDR;
				cur_byte = cmds.setup;
			end
			SEG_ADDR: begin
				nxt_seg = SEG_DATA;
				cur_byte = cmds.addr;
			end
			SEG_DATA: begin
				nxt_seg = head.pad ? SEG_PAD0 : SEG_CTRL;
				seg_done = !head.pad && !head.trailer;
				cur_byte = head.data;
			end
			SEG_PAD0: begin
				nxt_seg = SEG_PAD1;
			end
			SEG_PAD1: begin
				seg_done = !head.trailer;
			end
			SEG_CTRL: begin
				seg_done = 1'b1;
				cur_byte = cmds.ctrl;
			end
			default: begin
				seg_done = 1'b1;
			end
		endcase
		// Command segments open with a strobe, byte segments go straight to bits.
		nxt_start = (nxt_seg == SEG_DATA || nxt_seg == SEG_PAD0 || nxt_seg == SEG_PAD1)
			? CNT_FIRST_BIT : CNT_STROBE;
		seg_end = (eff_cnt == CNT_LAST_BIT);
		is_last = seg_end && seg_done;
		bit_idx = 3'(eff_cnt - CNT_FIRST_BIT);
		pop = emit && is_last;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			seg_q <= SEG_MODE;
			cnt_q <= CNT_STROBE;
			out_valid_q <= 1'b0;
		end else begin
			if (out_ready) begin
				out_valid_q <= emit;
			end
			if (emit) begin
				if (is_last) begin
					busy_q <= 1'b0;
				end else begin
					busy_q <= 1'b1;
					if (seg_end) begin
						seg_q <= nxt_seg;
						cnt_q <= nxt_start;
					end else begin
						seg_q <= eff_seg;
						cnt_q <= eff_cnt + CNT_W'(1);
					end
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			kind_q <= (eff_cnt == CNT_STROBE) ? SYM_STROBE : SYM_DATA;
			bit_q <= (eff_cnt == CNT_STROBE) ? 1'b0 : cur_byte[bit_idx];
			last_q <= is_last;
		end
	end

	assign out_valid = out_valid_q;
	assign symbol_kind = kind_q;
	assign bit_value = bit_q;
	assign last_symbol = last_q;

endmodule

@@ hdl/led_driver_frame_serializer_top.sv @@
// Top level of the LED driver frame serializer: command registers, front, queue, back.
// The serializer turns each display byte of a frame into serial symbols for a
// three-wire LED driver: a strobe pulse (symbol_kind 0) or one clocked data bit
// (symbol_kind 1), data bytes least significant bit first. The first byte of a
// frame is preceded by the mode, data setting and start address commands, each
// a strobe plus 8 bits; an odd-position byte is followed by two zero pad bytes;
// the last byte of the frame (lfs_pkg::FRAME_BYTES, default 32) is followed by
// the display control command. last_symbol marks the final symbol of each byte.
// Output rate is one symbol per clock when out_stall is low, set by the single
// back-end sequencer and its output register: a byte gives 8 symbols, plus 27
// at frame start, plus 16 at an odd position, plus 9 for the last byte, so 35
// at most. The front end and a two-entry queue take new bytes while the back
// end is still sending, so in_stall rises only once the queue is full. Write
// the command registers only while no transaction is in flight.
module led_driver_frame_serializer_top
	import lfs_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_stall,
	input  logic [BYTE_W-1:0]    display_byte,
	output logic                 out_valid,
	input  logic                 out_stall,
	output logic                 symbol_kind,
	output logic                 bit_value,
	output logic                 last_symbol,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [BYTE_W-1:0]    cfg_data
);

	`include "led_driver_frame_serializer_top_assert.svh"

	cmd_set_t cmds_q;
	q_stat_t  q_stat;
	logic     q_push;
	logic     q_pop;
	job_t     push_job;
	job_t     head;

	// Command registers: hold their reset values until software overwrites them.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cmds_q.mode <= RST_MODE;
			cmds_q.setup <= RST_SETUP;
			cmds_q.addr <= RST_ADDR;
			cmds_q.ctrl <= RST_CTRL;
		end else if (cfg_we) begin
			unique case (cfg_reg_t'(cfg_index))
				CFG_MODE:  cmds_q.mode <= cfg_data;
				CFG_SETUP: cmds_q.setup <= cfg_data;
				CFG_ADDR:  cmds_q.addr <= cfg_data;
				CFG_CTRL:  cmds_q.ctrl <= cfg_data;
			endcase
		end
	end

	// Front: accept a transaction, tag it with header, pad and trailer work.
	lfs_front u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.display_byte (display_byte),
		.q_stat       (q_stat),
		.push         (q_push),
		.job          (push_job)
	);

	// Queue: decouple byte intake from symbol output.
	lfs_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (q_push),
		.push_job (push_job),
		.pop      (q_pop),
		.head     (head),
		.q_stat   (q_stat)
	);

	// Back: send the head job symbol by symbol, drop it after its last symbol.
	lfs_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmds        (cmds_q),
		.head        (head),
		.q_stat      (q_stat),
		.pop         (q_pop),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.symbol_kind (symbol_kind),
		.bit_value   (bit_value),
		.last_symbol (last_symbol)
	);

	// A job leaves the queue exactly when its last symbol enters the output register.
	`LFS_ASSERT_NEXT(a_pop_shows_last, q_pop, out_valid && last_symbol, "pop without last symbol")
	// A strobe never drives the data line high.
	`LFS_ASSERT_NOW(a_strobe_low, out_valid && (symbol_kind == SYM_STROBE), !bit_value, "strobe with data high")
	// Nothing is popped from an empty queue.
	`LFS_ASSERT_NOW(a_no_pop_empty, q_stat.empty, !q_pop, "pop from empty queue")

endmodule

@@ test/lfs_checker.sv @@
// Symbol stream predictor and scoreboard for the LED driver frame serializer.
`timescale 1ns / 100ps
module lfs_checker
	import lfs_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	input  logic                 in_stall,
	input  logic [BYTE_W-1:0]    display_byte,
	input  logic                 out_valid,
	input  logic                 out_stall,
	input  logic                 symbol_kind,
	input  logic                 bit_value,
	input  logic                 last_symbol,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [BYTE_W-1:0]    cfg_data,
	output int                   fail_count,
	output int                   pending,
	output int                   byte_count,
	output int                   symbol_count,
	output int                   frame_count
);

	typedef struct packed {
		logic kind;
		logic level;
		logic last;
	} symbol_t;

	symbol_t  wire_symbols_q[$];
	symbol_t  byte_symbols[$];
	cmd_set_t cmds;
	int       next_pos;
	int       errors;
	int       bytes_seen;
	int       symbols_seen;
	int       frames_done;

	task automatic add_symbol(input logic kind, input logic level);
		symbol_t s;
		s.kind = kind;
		s.level = level;
		s.last = 1'b0;
		byte_symbols.push_back(s);
	endtask

	// Data bits go out least significant bit first.
	task automatic add_data(input logic [BYTE_W-1:0] value);
		for (int i = 0; i < BYTE_W; i++)
			add_symbol(SYM_DATA, value[i]);
	endtask

	task automatic add_command(input logic [BYTE_W-1:0] cmd);
		add_symbol(SYM_STROBE, 1'b0);
		add_data(cmd);
	endtask

	task automatic serialize_byte(input logic [BYTE_W-1:0] value);
		symbol_t tail;
		byte_symbols.delete();
		if (next_pos == 0) begin
			add_command(cmds.mode);
			add_command(cmds.setup);
			add_command(cmds.addr);
		end
		add_data(value);
		if (next_pos % 2 == 1) begin
			add_data(PAD_BYTE);
			add_data(PAD_BYTE);
		end
		if (next_pos == FRAME_BYTES - 1) begin
			add_command(cmds.ctrl);
			next_pos = 0;
			frames_done++;
		end else begin
			next_pos++;
		end
		tail = byte_symbols.pop_back();
		tail.last = 1'b1;
		byte_symbols.push_back(tail);
		foreach (byte_symbols[i])
			wire_symbols_q.push_back(byte_symbols[i]);
	endtask

	always @(posedge clk or negedge arst_n) begin
		symbol_t want;
		if (!arst_n) begin
			wire_symbols_q.delete();
			cmds.mode = RST_MODE;
			cmds.setup = RST_SETUP;
			cmds.addr = RST_ADDR;
			cmds.ctrl = RST_CTRL;
			next_pos = 0;
			errors = 0;
			bytes_seen = 0;
			symbols_seen = 0;
			frames_done = 0;
		end else begin
			if (cfg_we) begin
				case (cfg_reg_t'(cfg_index))
					CFG_MODE:  cmds.mode = cfg_data;
					CFG_SETUP: cmds.setup = cfg_data;
					CFG_ADDR:  cmds.addr = cfg_data;
					CFG_CTRL:  cmds.ctrl = cfg_data;
				endcase
			end
			if (in_valid && !in_stall) begin
				serialize_byte(display_byte);
				bytes_seen++;
			end
			if (out_valid && !out_stall) begin
				symbols_seen++;
				if (wire_symbols_q.size() == 0) begin
					$error("unexpected symbol: kind %0d bit %0d last %0d",
						symbol_kind, bit_value, last_symbol);
					errors++;
				end else begin
					want = wire_symbols_q.pop_front();
					if (symbol_kind !== want.kind) begin
						$error("symbol_kind: expected %0d, got %0d", want.kind, symbol_kind);
						errors++;
					end
					if (bit_value !== want.level) begin
						$error("bit_value: expected %0d, got %0d", want.level, bit_value);
						errors++;
					end
					if (last_symbol !== want.last) begin
						$error("last_symbol: expected %0d, got %0d", want.last, last_symbol);
						errors++;
					end
				end
			end
		end
		fail_count <= errors;
		pending <= wire_symbols_q.size();
		byte_count <= bytes_seen;
		symbol_count <= symbols_seen;
		frame_count <= frames_done;
	end

endmodule

@@ test/tb.sv @@
// Testbench top for the LED driver frame serializer: clock, reset, stimulus, verdict.
`timescale 1ns / 100ps
module tb;
	import lfs_pkg::*;

	logic                 clk;
	logic                 arst_n;
	logic                 in_valid;
	logic                 in_stall;
	logic [BYTE_W-1:0]    display_byte;
	logic                 out_valid;
	logic                 out_stall;
	logic                 symbol_kind;
	logic                 bit_value;
	logic                 last_symbol;
	logic                 cfg_we;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [BYTE_W-1:0]    cfg_data;

	int fail_count;
	int pending;
	int byte_count;
	int symbol_count;
	int frame_count;

	// Percent chance that the sender idles after a transaction; set per phase.
	int send_idle_pct;

	led_driver_frame_serializer_top DUT (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.display_byte (display_byte),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.symbol_kind  (symbol_kind),
		.bit_value    (bit_value),
		.last_symbol  (last_symbol),
		.cfg_we       (cfg_we),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data)
	);

	// The checker sees the same pins as the block and keeps its own copy of
	// the command registers and the frame position.
	lfs_checker u_checker (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.display_byte (display_byte),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.symbol_kind  (symbol_kind),
		.bit_value    (bit_value),
		.last_symbol  (last_symbol),
		.cfg_we       (cfg_we),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.fail_count   (fail_count),
		.pending      (pending),
		.byte_count   (byte_count),
		.symbol_count (symbol_count),
		.frame_count  (frame_count)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Slowest correct run: about 430 bytes, each up to 35 symbols, each symbol
	// held off by the longest receiver gap, plus the one long hold-off. The
	// timeout allows five times that.
	initial begin
		#50_000_000;
		$display("timeout with %0d symbols still expected", pending);
		$display("CHECKS FAILED");
		$finish;
	end

	// Gap length after a transaction: mostly none or short, now and then long.
	function automatic int pick_gap(input int idle_pct);
		int r;
		if ($urandom_range(0, 99) >= idle_pct)
			return 0;
		r = $urandom_range(0, 9);
		if (r < 7)
			return $urandom_range(1, 3);
		if (r < 9)
			return $urandom_range(4, 12);
		return $urandom_range(20, 60);
	endfunction

	// Offer one byte and hold it until the block takes it. Valid stays high
	// into the next transaction when no gap is drawn.
	task automatic send_byte(input logic [BYTE_W-1:0] value);
		int gap;
		in_valid <= 1'b1;
		display_byte <= value;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		gap = pick_gap(send_idle_pct);
		if (gap > 0) begin
			in_valid <= 1'b0;
			display_byte <= BYTE_W'($urandom_range(0, 255));
			repeat (gap) @(posedge clk);
		end
	endtask

	// Random byte, biased toward the all-zero and all-one extremes.
	function automatic logic [BYTE_W-1:0] pick_byte();
		int r;
		r = $urandom_range(0, 99);
		if (r < 10)
			return '0;
		if (r < 20)
			return '1;
		return BYTE_W'($urandom_range(0, 255));
	endfunction

	// Hold the sender until every predicted symbol has come out.
	task automatic wait_idle();
		in_valid <= 1'b0;
		do
			@(posedge clk);
		while (pending != 0);
	endtask

	// Write all four command registers, one per clock.
	task automatic write_cmds(input cmd_set_t c);
		cfg_reg_t idx;
		idx = idx.first();
		repeat (idx.num()) begin
			cfg_we <= 1'b1;
			cfg_index <= idx;
			case (idx)
				CFG_MODE:  cfg_data <= c.mode;
				CFG_SETUP: cfg_data <= c.setup;
				CFG_ADDR:  cfg_data <= c.addr;
				CFG_CTRL:  cfg_data <= c.ctrl;
			endcase
			@(posedge clk);
			idx = idx.next();
		end
		cfg_we <= 1'b0;
	endtask

	task automatic random_phase(input cmd_set_t c, input int idle_pct, input int count);
		wait_idle();
		write_cmds(c);
		send_idle_pct = idle_pct;
		repeat (count) send_byte(pick_byte());
	endtask

	// Receiver: random stall gaps, with stretches of no stalling, and one long
	// hold-off once the stream is well under way so the queue fills and the
	// block pushes back on its input.
	initial begin
		int received;
		int stall_left;
		bit held;
		received = 0;
		stall_left = 0;
		held = 1'b0;
		out_stall <= 1'b0;
		forever begin
			@(posedge clk);
			if (out_valid && !out_stall)
				received++;
			if (!held && received >= 1500) begin
				held = 1'b1;
				stall_left = 300;
			end else if (stall_left == 0) begin
				stall_left = pick_gap(((received / 300) % 3 == 0) ? 0 : 25);
			end
			if (stall_left > 0) begin
				out_stall <= 1'b1;
				stall_left--;
			end else begin
				out_stall <= 1'b0;
			end
		end
	end

	initial begin
		logic [BYTE_W-1:0] directed[24];
		cmd_set_t all_zero;
		cmd_set_t all_one;
		cmd_set_t mixed;
		cmd_set_t rand_a;
		cmd_set_t rand_b;

		directed = '{8'h00, 8'hFF, 8'h01, 8'h80, 8'hFE, 8'h7F, 8'hAA, 8'h55,
			8'h0F, 8'hF0, 8'h00, 8'hFF, 8'h33, 8'hCC, 8'h81, 8'h18,
			8'h02, 8'h40, 8'hFD, 8'hBF, 8'h5A, 8'hA5, 8'h00, 8'hFF};
		all_zero = '{mode: 8'h00, setup: 8'h00, addr: 8'h00, ctrl: 8'h00};
		all_one = '{mode: 8'hFF, setup: 8'hFF, addr: 8'hFF, ctrl: 8'hFF};
		mixed = '{mode: 8'h01, setup: 8'h80, addr: 8'h7F, ctrl: 8'hFE};
		rand_a = cmd_set_t'($urandom);
		rand_b = cmd_set_t'($urandom);

		// Drive every input to a known value from time zero.
		arst_n <= 1'b0;
		in_valid <= 1'b0;
		display_byte <= '0;
		cfg_we <= 1'b0;
		cfg_index <= CFG_MODE;
		cfg_data <= '0;
		send_idle_pct = 30;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed bytes under the reset command values: extremes and walking
		// patterns, crossing the frame start and both byte parities.
		foreach (directed[i])
			send_byte(directed[i]);

		// Random phases, each under a new command set; the frame position
		// carries across phases so frame starts and ends land under each set.
		// One phase runs with no sender idling at all.
		random_phase(all_zero, 30, 80);
		random_phase(all_one, 0, 80);
		random_phase(rand_a, 40, 80);
		random_phase(mixed, 20, 80);
		random_phase(rand_b, 60, 80);

		// Drain, then allow a little slack for any stray symbol to show up.
		wait_idle();
		repeat (50) @(posedge clk);

		$display("covered %0d display bytes, %0d frames completed, %0d symbols compared",
			byte_count, frame_count, symbol_count);
		$display("command sets: reset values, all zero, all ones, mixed, two random");
		if (fail_count == 0 && pending == 0) begin
			$display("ALL CHECKS PASSED");
		end else begin
			$display("CHECKS FAILED");
		end
		$finish;
	end

endmodule
